[rtl/rie_pkg.sv]
// ----------------------------------------------------------------------------
// rie_pkg: shared types and codes for the instruction execute block
// Opcodes, status and class codes, ALU functions and small control bundles.
// ----------------------------------------------------------------------------
package rie_pkg;

	// opcodes, bits 31:26 of the instruction word
	localparam logic [5:0] OP_ADD  = 6'h00;
	localparam logic [5:0] OP_XORI = 6'h0B;
	localparam logic [5:0] OP_LDW  = 6'h0C;
	localparam logic [5:0] OP_STW  = 6'h0D;
	localparam logic [5:0] OP_BZ   = 6'h0E;
	localparam logic [5:0] OP_BEQ  = 6'h0F;
	localparam logic [5:0] OP_JR   = 6'h10;
	localparam logic [5:0] OP_HALT = 6'h11;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HALTED   = 2'd1,
		ST_UNKNOWN  = 2'd2,
		ST_BAD_ADDR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CL_ARITH = 3'd0,
		CL_LOGIC = 3'd1,
		CL_MEM   = 3'd2,
		CL_CTRL  = 3'd3,
		CL_NONE  = 3'd4
	} iclass_t;

	// ALU function, opcode bits 3:1 of the ALU group
	typedef enum logic [2:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_MUL = 3'd2,
		FN_OR  = 3'd3,
		FN_AND = 3'd4,
		FN_XOR = 3'd5
	} alu_fn_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef struct packed {
		logic start;
		logic take;
	} pcm_ctl_t;

	typedef enum logic [1:0] {
		PCM_IDLE,
		PCM_QUOT,
		PCM_PROD,
		PCM_DONE
	} pcm_state_t;

endpackage

[rtl/rie_regfile.sv]
// ----------------------------------------------------------------------------
// rie_regfile: general register file
// Two registered read ports with write-through, one write port, and a valid
// bit per entry so that every register reads as zero until first written.
// ----------------------------------------------------------------------------
module rie_regfile #(
	parameter int REGISTER_COUNT = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(REGISTER_COUNT)-1:0] rd_addr_a,
	input  logic [$clog2(REGISTER_COUNT)-1:0] rd_addr_b,
	output logic [31:0]                       rd_data_a,
	output logic [31:0]                       rd_data_b,
	input  logic                              wr_en,
	input  logic [$clog2(REGISTER_COUNT)-1:0] wr_addr,
	input  logic [31:0]                       wr_data
);
	logic [31:0]               mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] vld_q;
	logic [31:0]               rdata_a_q;
	logic [31:0]               rdata_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// pass a same-edge write straight to the read register
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == rd_addr_a) begin
			rdata_a_q <= wr_data;
		end else begin
			rdata_a_q <= vld_q[rd_addr_a] ? mem[rd_addr_a] : 32'd0;
		end
		if (wr_en && wr_addr == rd_addr_b) begin
			rdata_b_q <= wr_data;
		end else begin
			rdata_b_q <= vld_q[rd_addr_b] ? mem[rd_addr_b] : 32'd0;
		end
	end

	assign rd_data_a = rdata_a_q;
	assign rd_data_b = rdata_b_q;

endmodule

[rtl/rie_dmem.sv]
// ----------------------------------------------------------------------------
// rie_dmem: word data store
// Single-port memory with registered read data. After reset a clearing pass
// writes zero to every word, one per cycle, while busy is high.
// ----------------------------------------------------------------------------
module rie_dmem #(
	parameter int DATA_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rie_pkg::mem_cmd_t             cmd,
	input  logic [$clog2(DATA_WORDS)-1:0] addr,
	input  logic [31:0]                   wdata,
	output logic [31:0]                   rdata,
	output logic                          busy
);
	import rie_pkg::*;

	localparam int AW = $clog2(DATA_WORDS);

	logic [31:0]   mem [DATA_WORDS];
	logic [31:0]   rdata_q;
	logic [AW-1:0] clr_cnt_q;
	logic          clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DATA_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= 32'd0;
		end else if (cmd.wr) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

[rtl/rie_pcmod.sv]
// ----------------------------------------------------------------------------
// rie_pcmod: program counter wrap unit
// Reduces a 32-bit jump or branch target modulo PROGRAM_WORDS by reciprocal
// multiply, back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module rie_pcmod #(
	parameter int PROGRAM_WORDS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rie_pkg::pcm_ctl_t                ctl,
	input  logic [31:0]                      target,
	output logic                             done,
	output logic [$clog2(PROGRAM_WORDS)-1:0] result
);
	import rie_pkg::*;

	localparam int PCW = $clog2(PROGRAM_WORDS);
	localparam int MW  = 33 - PCW;
	localparam int PWW = PCW + 1;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << 32) / PROGRAM_WORDS);
	localparam logic [31:0]   PW32  = 32'(PROGRAM_WORDS);

	pcm_state_t         state_q;
	pcm_state_t         state_d;
	logic [31:0]        t_q;
	logic [MW-1:0]      q_q;
	logic [31:0]        p_q;
	logic [32+MW-1:0]   quot_prod;
	logic [MW+PWW-1:0]  back_prod;
	logic [31:0]        diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PCM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			PCM_IDLE: begin
				if (ctl.start) begin
					state_d = PCM_QUOT;
				end
			end
			PCM_QUOT: state_d = PCM_PROD;
			PCM_PROD: state_d = PCM_DONE;
			PCM_DONE: begin
				done = 1'b1;
				if (ctl.take) begin
					state_d = PCM_IDLE;
				end
			end
			default: state_d = PCM_IDLE;
		endcase
	end

	// quotient estimate is low by at most one
	assign quot_prod = (32 + MW)'(t_q) * (32 + MW)'(RECIP);
	assign back_prod = (MW + PWW)'(q_q) * (MW + PWW)'(PROGRAM_WORDS);

	always_ff @(posedge clk) begin
		if (state_q == PCM_IDLE && ctl.start) begin
			t_q <= target;
		end
		if (state_q == PCM_QUOT) begin
			q_q <= quot_prod[32+MW-1:32];
		end
		if (state_q == PCM_PROD) begin
			p_q <= 32'(back_prod);
		end
	end

	assign diff   = t_q - p_q;
	assign result = PCW'((diff >= PW32) ? diff - PW32 : diff);

endmodule

[rtl/risc_instruction_execute.sv]
// ----------------------------------------------------------------------------
// risc_instruction_execute: single-pass load/store instruction execute
//
//   channel  dir  beats      contents
//   s_*      in   1/instr    tdata[31:0] instruction_word
//   m_*      out  1/instr    tdata: pc, status, flags, register and memory
//                            writes; tuser[2:0] instruction class
//
// One instruction per cycle while neither a taken branch nor a stalled output
// holds the execute stage; each result is registered in the result stage.
// A taken branch or jump waits while the PC wrap unit runs QUOT, PROD, DONE.
// After reset the data store clears every word with s_tready low.
// A stalled output holds the execute stage; an empty execute stage still
// takes the next instruction while the result waits.
// ----------------------------------------------------------------------------
module risc_instruction_execute #(
	parameter int REGISTER_COUNT = 32,
	parameter int DATA_WORDS     = 1024,
	parameter int PROGRAM_WORDS  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] instruction_word
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] next_pc, [11:10] status, [12] branch_taken, [13] reg_write,
	// [18:14] reg_index, [50:19] reg_value, [51] mem_write, [61:52] mem_index,
	// [93:62] mem_value, [95:94] zero
	output logic [95:0] m_tdata,
	output logic [2:0]  m_tuser    // [2:0] instr_class
);
	import rie_pkg::*;

	localparam int RW  = $clog2(REGISTER_COUNT);
	localparam int AW  = $clog2(DATA_WORDS);
	localparam int PCW = $clog2(PROGRAM_WORDS);

	// register field (0..31) reduced modulo REGISTER_COUNT
	function automatic logic [32*RW-1:0] reg_map_build();
		logic [32*RW-1:0] m;
		int               r;
		m = '0;
		r = 0;
		for (int i = 0; i < 32; i++) begin
			m[i*RW +: RW] = RW'(r);
			r = (r == REGISTER_COUNT - 1) ? 0 : r + 1;
		end
		return m;
	endfunction

	localparam logic [32*RW-1:0] REG_MAP = reg_map_build();

	function automatic logic [RW-1:0] reg_sel(input logic [4:0] f);
		return REG_MAP[f*RW +: RW];
	endfunction

	// execute stage
	logic          s_acc;
	logic          s1_valid_q;
	logic [31:0]   instr_s1;
	logic          s1_adv;
	logic [PCW-1:0] pc_q;
	status_t       stop_q;

	logic [5:0]    op;
	logic [RW-1:0] rs;
	logic [RW-1:0] rt;
	logic [RW-1:0] rd;
	logic [31:0]   imm;
	alu_fn_t       alu_fn;

	logic [RW-1:0] rd_addr_a;
	logic [RW-1:0] rd_addr_b;
	logic [31:0]   rf_a;
	logic [31:0]   rf_b;
	logic [31:0]   a_val;
	logic [31:0]   b_val;
	logic [31:0]   alu_b;
	logic [31:0]   alu_res;

	logic [31:0]   addr_sum;
	logic [29:0]   word_idx;
	logic          addr_bad;
	logic          br_taken;
	logic [31:0]   br_target;
	logic [PCW-1:0] pc_inc;
	logic          needs_mod;

	pcm_ctl_t      pcm_ctl;
	logic          pcm_done;
	logic [PCW-1:0] pcm_result;

	mem_cmd_t      ex_cmd;
	mem_cmd_t      dm_cmd;
	logic [31:0]   dm_rdata;
	logic          dm_busy;

	// next result
	logic [PCW-1:0] n_pc;
	status_t       n_status;
	status_t       n_stop;
	iclass_t       n_class;
	logic          n_taken;
	logic          n_rw;
	logic [RW-1:0] n_ridx;
	logic [31:0]   n_rval;
	logic          n_mw;
	logic [9:0]    n_midx;
	logic [31:0]   n_mval;
	logic          n_load;

	// result stage
	logic          m_valid_q;
	logic          wb_pend_s2;
	logic [9:0]    npc_s2;
	status_t       status_s2;
	iclass_t       class_s2;
	logic          taken_s2;
	logic          rw_s2;
	logic [RW-1:0] ridx_s2;
	logic [31:0]   rval_s2;
	logic          mw_s2;
	logic [9:0]    midx_s2;
	logic [31:0]   mval_s2;
	logic          load_s2;
	logic [31:0]   wb_val;
	logic [31:0]   out_rval;
	logic [31:0]   out_mval;

	// ---------------------------------------------------------------- handshake
	assign s1_adv   = s1_valid_q && (!needs_mod || pcm_done) && (!m_valid_q || m_tready);
	assign s_tready = !dm_busy && (!s1_valid_q || s1_adv);
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			instr_s1 <= s_tdata;
		end
	end

	// ------------------------------------------------------------------ decode
	assign op     = instr_s1[31:26];
	assign rs     = reg_sel(instr_s1[25:21]);
	assign rt     = reg_sel(instr_s1[20:16]);
	assign rd     = reg_sel(instr_s1[15:11]);
	assign imm    = {{16{instr_s1[15]}}, instr_s1[15:0]};
	assign alu_fn = alu_fn_t'(op[3:1]);

	// reread the held instruction's operands each cycle so later writes land
	assign rd_addr_a = reg_sel(s_acc ? s_tdata[25:21] : instr_s1[25:21]);
	assign rd_addr_b = reg_sel(s_acc ? s_tdata[20:16] : instr_s1[20:16]);

	rie_regfile #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr_en     (wb_pend_s2),
		.wr_addr   (ridx_s2),
		.wr_data   (wb_val)
	);

	// forward the result stage's write until it reaches the register file
	assign wb_val = load_s2 ? dm_rdata : rval_s2;
	assign a_val  = (wb_pend_s2 && ridx_s2 == rs) ? wb_val : rf_a;
	assign b_val  = (wb_pend_s2 && ridx_s2 == rt) ? wb_val : rf_b;

	// --------------------------------------------------------------------- ALU
	assign alu_b = op[0] ? imm : b_val;

	always_comb begin
		unique case (alu_fn)
			FN_ADD:  alu_res = a_val + alu_b;
			FN_SUB:  alu_res = a_val - alu_b;
			FN_MUL:  alu_res = a_val * alu_b;
			FN_OR:   alu_res = a_val | alu_b;
			FN_AND:  alu_res = a_val & alu_b;
			FN_XOR:  alu_res = a_val ^ alu_b;
			default: alu_res = 32'd0;
		endcase
	end

	// ------------------------------------------------------ address and branch
	assign addr_sum = a_val + imm;
	assign word_idx = addr_sum[31:2];
	assign addr_bad = addr_sum[31] || (addr_sum[1:0] != 2'b00) ||
		(word_idx >= 30'(DATA_WORDS));

	always_comb begin
		unique case (op)
			OP_BZ:   br_taken = (a_val == 32'd0);
			OP_BEQ:  br_taken = (a_val == b_val);
			OP_JR:   br_taken = 1'b1;
			default: br_taken = 1'b0;
		endcase
	end

	assign br_target = (op == OP_JR) ? a_val : 32'(pc_q) + imm;
	assign pc_inc    = (pc_q == PCW'(PROGRAM_WORDS - 1)) ? '0 : pc_q + 1'b1;
	assign needs_mod = s1_valid_q && (stop_q == ST_OK) && br_taken;

	assign pcm_ctl.start = needs_mod;
	assign pcm_ctl.take  = s1_adv && needs_mod;

	rie_pcmod #(
		.PROGRAM_WORDS(PROGRAM_WORDS)
	) u_pcmod (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pcm_ctl),
		.target (br_target),
		.done   (pcm_done),
		.result (pcm_result)
	);

	// ------------------------------------------------------------ result build
	always_comb begin
		n_pc     = pc_q;
		n_status = stop_q;
		n_stop   = stop_q;
		n_class  = CL_NONE;
		n_taken  = 1'b0;
		n_rw     = 1'b0;
		n_ridx   = '0;
		n_rval   = 32'd0;
		n_mw     = 1'b0;
		n_midx   = 10'd0;
		n_mval   = 32'd0;
		n_load   = 1'b0;
		ex_cmd   = '0;
		if (stop_q == ST_OK) begin
			unique case (op) inside
				[OP_ADD:OP_XORI]: begin
					n_pc    = pc_inc;
					n_class = (alu_fn == FN_ADD || alu_fn == FN_SUB || alu_fn == FN_MUL)
						? CL_ARITH : CL_LOGIC;
					n_rw    = 1'b1;
					n_ridx  = op[0] ? rt : rd;
					n_rval  = alu_res;
				end
				OP_LDW, OP_STW: begin
					n_class = CL_MEM;
					if (addr_bad) begin
						n_status = ST_BAD_ADDR;
						n_stop   = ST_BAD_ADDR;
					end else begin
						n_pc   = pc_inc;
						n_midx = 10'(word_idx);
						if (op == OP_LDW) begin
							n_load    = 1'b1;
							n_rw      = 1'b1;
							n_ridx    = rt;
							ex_cmd.rd = 1'b1;
						end else begin
							n_mw      = 1'b1;
							n_mval    = b_val;
							ex_cmd.wr = 1'b1;
						end
					end
				end
				OP_BZ, OP_BEQ, OP_JR: begin
					n_class = CL_CTRL;
					n_taken = br_taken;
					n_pc    = br_taken ? pcm_result : pc_inc;
				end
				OP_HALT: begin
					n_class  = CL_CTRL;
					n_status = ST_HALTED;
					n_stop   = ST_HALTED;
				end
				default: begin
					n_status = ST_UNKNOWN;
					n_stop   = ST_UNKNOWN;
				end
			endcase
		end
	end

	assign dm_cmd.rd = ex_cmd.rd && s1_adv;
	assign dm_cmd.wr = ex_cmd.wr && s1_adv;

	rie_dmem #(
		.DATA_WORDS(DATA_WORDS)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dm_cmd),
		.addr   (word_idx[AW-1:0]),
		.wdata  (b_val),
		.rdata  (dm_rdata),
		.busy   (dm_busy)
	);

	// --------------------------------------------------------- architected state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			stop_q <= ST_OK;
		end else if (s1_adv) begin
			pc_q   <= n_pc;
			stop_q <= n_stop;
		end
	end

	// ------------------------------------------------------------ result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			wb_pend_s2 <= 1'b0;
		end else begin
			// write back once, at the edge after the result lands
			wb_pend_s2 <= s1_adv && n_rw;
			if (s1_adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			npc_s2    <= 10'(n_pc);
			status_s2 <= n_status;
			class_s2  <= n_class;
			taken_s2  <= n_taken;
			rw_s2     <= n_rw;
			ridx_s2   <= n_ridx;
			rval_s2   <= n_rval;
			mw_s2     <= n_mw;
			midx_s2   <= n_midx;
			mval_s2   <= n_mval;
			load_s2   <= n_load;
		end
	end

	assign out_rval = load_s2 ? dm_rdata : rval_s2;
	assign out_mval = load_s2 ? dm_rdata : mval_s2;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_mval, midx_s2, mw_s2, out_rval, 5'(ridx_s2), rw_s2,
		taken_s2, status_s2, npc_s2};
	assign m_tuser  = class_s2;

endmodule

[rtl/rie_checker.sv]
// ----------------------------------------------------------------------------
// rie_checker: port-level checks for the instruction execute block
// Watches the stream ports for ordering, occupancy and sticky stop behavior.
// ----------------------------------------------------------------------------
module rie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import rie_pkg::*;

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] inflight_q;
	logic       stopped_q;
	logic [1:0] code_q;
	logic [9:0] held_pc_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
			stopped_q  <= 1'b0;
			code_q     <= 2'd0;
			held_pc_q  <= 10'd0;
		end else begin
			inflight_q <= 2'(inflight_q + 2'(in_xfer) - 2'(out_xfer));
			if (out_xfer && m_tdata[11:10] != ST_OK && !stopped_q) begin
				stopped_q <= 1'b1;
				code_q    <= m_tdata[11:10];
				held_pc_q <= m_tdata[9:0];
			end
		end
	end

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 2'd0)
		else $error("result without an instruction in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more than two instructions in flight");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && stopped_q |->
			m_tdata[11:10] == code_q && m_tdata[9:0] == held_pc_q &&
			m_tuser == CL_NONE && m_tdata[13] == 1'b0 && m_tdata[51] == 1'b0)
		else $error("stopped core changed state");

endmodule

bind risc_instruction_execute rie_checker u_rie_checker (.*);

[sim/risc_instruction_execute_chk.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc_instruction_execute_chk: result checker for the instruction execute block
// Watches both stream channels, runs its own copy of the core state on every
// accepted instruction, and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module risc_instruction_execute_chk #(
	parameter int REGISTER_COUNT = 32,
	parameter int DATA_WORDS     = 1024,
	parameter int PROGRAM_WORDS  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [2:0]  m_tuser,
	output int          mismatches,
	output int          results_due
);
	import rie_pkg::*;

	localparam logic [31:0] REG_MOD = REGISTER_COUNT;
	localparam logic [31:0] DW_MOD  = DATA_WORDS;
	localparam logic [31:0] PC_MOD  = PROGRAM_WORDS;

	typedef struct {
		logic [9:0]  next_pc;
		status_t     status;
		iclass_t     iclass;
		logic        taken;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [9:0]  mem_index;
		logic [31:0] mem_value;
	} exec_result_t;

	exec_result_t exec_results[$];

	logic [31:0] regs [REGISTER_COUNT];
	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] pc_q;
	status_t     stop_q;

	function automatic logic [31:0] wrap_pc(logic [31:0] target);
		return target % PC_MOD;
	endfunction

	// Execute one instruction on the local core state.
	function automatic exec_result_t execute_instr(logic [31:0] word);
		exec_result_t r;
		logic [5:0]  op;
		logic [4:0]  rs, rt, rd, dst;
		logic [31:0] imm, a, b, v, addr, target;
		alu_fn_t     fn;
		logic        taken;
		op  = word[31:26];
		rs  = 5'(word[25:21] % REG_MOD);
		rt  = 5'(word[20:16] % REG_MOD);
		rd  = 5'(word[15:11] % REG_MOD);
		imm = {{16{word[15]}}, word[15:0]};
		r.status    = ST_OK;
		r.iclass    = CL_NONE;
		r.taken     = 1'b0;
		r.reg_write = 1'b0;
		r.reg_index = '0;
		r.reg_value = '0;
		r.mem_write = 1'b0;
		r.mem_index = '0;
		r.mem_value = '0;
		if (stop_q != ST_OK) begin
			r.status = stop_q;
		end else if (op <= OP_XORI) begin
			fn  = alu_fn_t'(op[3:1]);
			a   = regs[rs];
			b   = op[0] ? imm : regs[rt];
			dst = op[0] ? rt : rd;
			case (fn)
				FN_ADD: v = a + b;
				FN_SUB: v = a - b;
				FN_MUL: v = a * b;
				FN_OR: v = a | b;
				FN_AND: v = a & b;
				default: v = a ^ b;
			endcase
			regs[dst] = v;
			pc_q = wrap_pc(pc_q + 1);
			r.iclass    = (fn == FN_ADD || fn == FN_SUB || fn == FN_MUL) ? CL_ARITH : CL_LOGIC;
			r.reg_write = 1'b1;
			r.reg_index = dst;
			r.reg_value = v;
		end else if (op == OP_LDW || op == OP_STW) begin
			addr = regs[rs] + imm;
			r.iclass = CL_MEM;
			if (addr[31] || addr[1:0] != 2'b00 || {2'b00, addr[31:2]} >= DW_MOD) begin
				stop_q   = ST_BAD_ADDR;
				r.status = ST_BAD_ADDR;
			end else begin
				if (op == OP_LDW) begin
					v = dmem[addr[31:2]];
					regs[rt]    = v;
					r.reg_write = 1'b1;
					r.reg_index = rt;
					r.reg_value = v;
					r.mem_value = v;
				end else begin
					dmem[addr[31:2]] = regs[rt];
					r.mem_write = 1'b1;
					r.mem_value = regs[rt];
				end
				r.mem_index = 10'(addr[31:2]);
				pc_q = wrap_pc(pc_q + 1);
			end
		end else if (op == OP_BZ || op == OP_BEQ || op == OP_JR) begin
			r.iclass = CL_CTRL;
			if (op == OP_JR) begin
				taken  = 1'b1;
				target = regs[rs];
			end else begin
				taken  = (op == OP_BZ) ? (regs[rs] == 0) : (regs[rs] == regs[rt]);
				target = pc_q + imm;
			end
			pc_q = taken ? wrap_pc(target) : wrap_pc(pc_q + 1);
			r.taken = taken;
		end else if (op == OP_HALT) begin
			stop_q   = ST_HALTED;
			r.status = ST_HALTED;
			r.iclass = CL_CTRL;
		end else begin
			stop_q   = ST_UNKNOWN;
			r.status = ST_UNKNOWN;
		end
		r.next_pc = 10'(pc_q);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		exec_result_t want;
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			pc_q   = '0;
			stop_q = ST_OK;
			exec_results.delete();
			mismatches  = 0;
			results_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (exec_results.size() == 0) begin
					mismatches++;
					$display("%0t: result mismatch: expected none, actual %h / %h",
						$time, m_tdata, m_tuser);
				end else begin
					want = exec_results.pop_front();
					check_field("next_pc", want.next_pc, m_tdata[9:0]);
					check_field("status", want.status, m_tdata[11:10]);
					check_field("branch_taken", want.taken, m_tdata[12]);
					check_field("reg_write", want.reg_write, m_tdata[13]);
					check_field("reg_index", want.reg_index, m_tdata[18:14]);
					check_field("reg_value", want.reg_value, m_tdata[50:19]);
					check_field("mem_write", want.mem_write, m_tdata[51]);
					check_field("mem_index", want.mem_index, m_tdata[61:52]);
					check_field("mem_value", want.mem_value, m_tdata[93:62]);
					check_field("pad", '0, m_tdata[95:94]);
					check_field("instr_class", want.iclass, m_tuser);
				end
			end
			if (s_tvalid && s_tready)
				exec_results.push_back(execute_instr(s_tdata));
			results_due = exec_results.size();
		end
	end

endmodule

[sim/risc_instruction_execute_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc_instruction_execute_tb: stimulus and verdict for the instruction execute block
// Runs a directed program over the opcode corners, then random instruction
// mixes with well-formed load/store sequences, and ends in one stopping cause.
// ----------------------------------------------------------------------------
module risc_instruction_execute_tb;
	import rie_pkg::*;

	localparam int REGISTER_COUNT = 32;
	localparam int DATA_WORDS     = 1024;
	localparam int PROGRAM_WORDS  = 1024;
	localparam int LIVE_ITEMS     = 830;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;
	int          mismatches;
	int          results_due;

	int sent = 0;
	bit tx_burst = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	risc_instruction_execute #(
		.REGISTER_COUNT(REGISTER_COUNT),
		.DATA_WORDS(DATA_WORDS),
		.PROGRAM_WORDS(PROGRAM_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	risc_instruction_execute_chk #(
		.REGISTER_COUNT(REGISTER_COUNT),
		.DATA_WORDS(DATA_WORDS),
		.PROGRAM_WORDS(PROGRAM_WORDS)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	function automatic logic [5:0] alu_op(alu_fn_t fn, bit immf);
		return {2'b00, fn, immf};
	endfunction

	function automatic logic [31:0] enc_r(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd);
		return {op, rs, rt, rd, 11'($urandom)};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// Favor a few registers so operands collide and branches get taken.
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_instr(input logic [31:0] word);
		int gap;
		if (sent % 64 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
		gap = tx_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Zero a base register, load a base into it, then access the data store
	// through it; with to_fault set the single access hits a bad address.
	task automatic mem_burst(input bit to_fault);
		logic [4:0] base_r, data_r;
		logic [5:0] op;
		int base, target, k, n;
		base_r = 5'($urandom);
		base   = int'($urandom_range(0, 32767)) - 16384;
		push_instr(enc_i(alu_op(FN_AND, 1'b1), base_r, base_r, 16'h0000));
		push_instr(enc_i(alu_op(FN_ADD, 1'b1), base_r, base_r, 16'(base)));
		n = to_fault ? 1 : $urandom_range(1, 3);
		repeat (n) begin
			if (to_fault) begin
				case ($urandom_range(0, 2))
					0: begin
						k = $urandom_range(1, 64);
						target = -4 * k;
					end
					1: target = 4 * int'($urandom_range(0, DATA_WORDS - 1))
						+ int'($urandom_range(1, 3));
					default: target = 4 * DATA_WORDS + 4 * int'($urandom_range(0, 255));
				endcase
			end else begin
				case ($urandom_range(0, 7))
					0: target = 0;
					1: target = 4 * (DATA_WORDS - 1);
					2, 3: target = 4 * int'($urandom_range(0, DATA_WORDS - 1));
					default: target = 4 * int'($urandom_range(0, 15));
				endcase
			end
			// keep the data register off the base so a load cannot move it
			data_r = 5'(base_r + 5'($urandom_range(1, 31)));
			op = ($urandom_range(0, 1) == 0) ? OP_LDW : OP_STW;
			push_instr(enc_i(op, base_r, data_r, 16'(target - base)));
		end
	endtask

	task automatic random_instr();
		logic [5:0] op;
		case ($urandom_range(0, 3))
			0: push_instr(enc_i(OP_BZ, pick_reg(), pick_reg(), pick_imm()));
			1: push_instr(enc_i(OP_BEQ, pick_reg(), pick_reg(), pick_imm()));
			2: push_instr({OP_JR, pick_reg(), 21'($urandom)});
			default: begin
				op = 6'($urandom_range(OP_ADD, OP_XORI));
				if (op[0])
					push_instr(enc_i(op, pick_reg(), pick_reg(), pick_imm()));
				else
					push_instr(enc_r(op, pick_reg(), pick_reg(), pick_reg()));
			end
		endcase
	endtask

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, burst stretches, and one long hold-off.
	initial begin : drain
		int got;
		int stall;
		bit rx_burst;
		got = 0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if (got % 50 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			stall = rx_burst ? 0 : $urandom_range(0, 16);
			if (got == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got++;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// corners of the ALU, the data store and the branches
		push_instr(enc_i(alu_op(FN_ADD, 1'b1), 5'd0, 5'd1, 16'h7FFF));
		push_instr(enc_i(alu_op(FN_ADD, 1'b1), 5'd0, 5'd2, 16'h8000));
		push_instr(enc_r(alu_op(FN_MUL, 1'b0), 5'd1, 5'd2, 5'd3));
		push_instr(enc_r(alu_op(FN_SUB, 1'b0), 5'd2, 5'd1, 5'd4));
		push_instr(enc_i(alu_op(FN_MUL, 1'b1), 5'd2, 5'd5, 16'h8000));
		push_instr(enc_i(alu_op(FN_MUL, 1'b1), 5'd5, 5'd6, 16'h0004));
		push_instr(enc_i(alu_op(FN_SUB, 1'b1), 5'd0, 5'd7, 16'h0001));
		push_instr(enc_r(alu_op(FN_ADD, 1'b0), 5'd7, 5'd7, 5'd8));
		push_instr(enc_r(alu_op(FN_OR, 1'b0), 5'd1, 5'd2, 5'd9));
		push_instr(enc_i(alu_op(FN_OR, 1'b1), 5'd0, 5'd10, 16'hFFFF));
		push_instr(enc_r(alu_op(FN_AND, 1'b0), 5'd7, 5'd1, 5'd11));
		push_instr(enc_i(alu_op(FN_AND, 1'b1), 5'd7, 5'd12, 16'h8000));
		push_instr(enc_r(alu_op(FN_XOR, 1'b0), 5'd7, 5'd1, 5'd13));
		push_instr(enc_i(alu_op(FN_XOR, 1'b1), 5'd31, 5'd31, 16'hFFFF));
		push_instr(enc_i(OP_STW, 5'd6, 5'd7, 16'h0FFC));
		push_instr(enc_i(OP_LDW, 5'd6, 5'd14, 16'h0FFC));
		push_instr(enc_i(OP_LDW, 5'd6, 5'd15, 16'h0000));
		push_instr(enc_i(OP_STW, 5'd6, 5'd31, 16'h0000));
		push_instr(enc_i(OP_LDW, 5'd6, 5'd16, 16'h0000));
		push_instr(enc_i(OP_BZ, 5'd6, 5'd0, 16'hFFFF));
		push_instr(enc_i(OP_BZ, 5'd1, 5'd0, 16'h0005));
		push_instr(enc_i(OP_BEQ, 5'd7, 5'd7, 16'h8000));
		push_instr(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0003));
		push_instr({OP_JR, 5'd7, 21'h1FFFFF});
		push_instr({OP_JR, 5'd2, 21'h000000});
		push_instr(enc_i(alu_op(FN_ADD, 1'b1), 5'd0, 5'd0, 16'h0005));

		while (sent < LIVE_ITEMS) begin
			if ($urandom_range(0, 9) < 4)
				mem_burst(1'b0);
			else
				random_instr();
		end

		// one stopping cause per run, then a few words the core must ignore
		case ($urandom_range(0, 2))
			0: push_instr({OP_HALT, 26'($urandom)});
			1: push_instr({6'($urandom_range(OP_HALT + 1, 63)), 26'($urandom)});
			default: mem_burst(1'b1);
		endcase
		repeat (6) push_instr($urandom);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
